FILE: rtl/lnis_pkg.sv
`default_nettype none

package lnis_pkg;

   localparam int VALUE_W       = 16;
   localparam int LENGTH_W      = 6;
   localparam int DEF_MAX_ITEMS = 32;

   localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] length;
      logic                overflow;
   } rsp_type;

   // operation of the shared compare / max unit
   typedef enum logic [1:0] {
      ALU_INIT,
      ALU_SWEEP,
      ALU_SCAN
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TAIL_RD,
      ST_TAIL_LD,
      ST_INIT,
      ST_HEAD_RD,
      ST_HEAD_LD,
      ST_SWEEP,
      ST_DRAIN,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic idle;
      logic resp_valid;
   } seq_status_type;

endpackage

`default_nettype wire

FILE: rtl/lnis_ram.sv
`default_nettype none

module lnis_ram import lnis_pkg::*; #(
   parameter int WIDTH  = VALUE_W,
   parameter int DEPTH  = DEF_MAX_ITEMS,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/lnis_alu.sv
`default_nettype none

module lnis_alu import lnis_pkg::*; #(
   parameter int LW = 6
) (
   input  wire alu_op_type                op,
   input  wire logic signed [VALUE_W-1:0] a_val,
   input  wire logic signed [VALUE_W-1:0] b_val,
   input  wire logic        [LW-1:0]      below,
   input  wire logic        [LW-1:0]      diag,
   input  wire logic        [LW-1:0]      best,
   output logic             [LW-1:0]      result
);

   logic          gt;
   logic [LW-1:0] cand;
   logic [LW-1:0] mx;

   always_comb begin
      gt   = a_val > b_val;
      cand = (op == ALU_SCAN) ? best : diag + LW'(1);
      mx   = (cand > below) ? cand : below;
      case (op)
         ALU_INIT:  result = gt ? '0 : LW'(1);
         ALU_SWEEP: result = gt ? below : mx;
         ALU_SCAN:  result = mx;
         default:   result = below;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/lnis_seq.sv
`default_nettype none

module lnis_seq import lnis_pkg::*; #(
   parameter int MAX_ITEMS = DEF_MAX_ITEMS,
   parameter int AW        = 5,
   parameter int CW        = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire req_type               req,
   input  wire logic                  rsp_ready,
   output seq_status_type             status,
   output logic          [CW-1:0]     best,
   output logic                       overflow,
   // value store
   output logic                       val_we,
   output logic          [AW-1:0]     val_waddr,
   input  wire logic signed [VALUE_W-1:0] val_rdata,
   // working row
   output logic                       row_we,
   output logic          [AW-1:0]     row_waddr,
   input  wire logic     [CW-1:0]     row_rdata,
   output logic          [AW-1:0]     rd_addr,
   // shared unit
   output alu_op_type                 alu_op,
   output logic signed   [VALUE_W-1:0] alu_a,
   output logic          [CW-1:0]     alu_diag,
   input  wire logic     [CW-1:0]     alu_result
);

   state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] n_ff, n_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic          p_valid_ff, p_valid_in;
   alu_op_type    p_op_ff, p_op_in;
   logic [AW-1:0] p_addr_ff, p_addr_in;
   logic signed [VALUE_W-1:0] vi_ff, vi_in;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] best_ff, best_in;

   logic          accept;
   logic          room;
   logic [CW-1:0] nm1;
   logic [CW-1:0] nm2;
   logic [AW-1:0] last_idx;
   logic          issuing;
   logic          pass_end;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign room     = cnt_ff < CW'(MAX_ITEMS);
   assign nm1      = n_ff - CW'(1);
   assign nm2      = n_ff - CW'(2);
   assign last_idx = nm1[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && req.is_last) state_in = ST_TAIL_RD;
         ST_TAIL_RD: state_in = ST_TAIL_LD;
         ST_TAIL_LD: state_in = ST_INIT;
         ST_INIT: begin
            if (j_ff == last_idx) begin
               state_in = (n_ff == CW'(1)) ? ST_DRAIN : ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD_LD;
         ST_HEAD_LD: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (j_ff == i_ff) begin
               state_in = (i_ff == '0) ? ST_DRAIN : ST_HEAD_RD;
            end
         end
         ST_DRAIN:   state_in = ST_SCAN;
         ST_SCAN:    if (j_ff == last_idx) state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_RESP;
         ST_RESP:    if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cnt_in     = cnt_ff;
      drop_in    = drop_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      vi_in      = vi_ff;
      diag_in    = diag_ff;
      best_in    = best_ff;
      issuing    = 1'b0;
      pass_end   = 1'b0;
      p_op_in    = p_op_ff;
      rd_addr    = j_ff;
      val_we     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            val_we = accept && room;
            if (accept) begin
               if (room) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req.is_last) begin
                  n_in    = room ? cnt_ff + CW'(1) : cnt_ff;
                  ovf_in  = drop_ff | ~room;
                  cnt_in  = '0;
                  drop_in = 1'b0;
               end
            end
         end
         ST_TAIL_RD: rd_addr = last_idx;
         ST_TAIL_LD: vi_in = val_rdata;
         ST_INIT: begin
            issuing  = 1'b1;
            p_op_in  = ALU_INIT;
            pass_end = j_ff == last_idx;
            if (pass_end) begin
               i_in = nm2[AW-1:0];
            end
         end
         ST_HEAD_RD: rd_addr = i_ff;
         ST_HEAD_LD: begin
            vi_in   = val_rdata;
            diag_in = row_rdata;
         end
         ST_SWEEP: begin
            issuing  = 1'b1;
            p_op_in  = ALU_SWEEP;
            pass_end = j_ff == i_ff;
            if (pass_end && i_ff != '0) begin
               i_in = i_ff - AW'(1);
            end
         end
         ST_DRAIN: best_in = '0;
         ST_SCAN: begin
            issuing  = 1'b1;
            p_op_in  = ALU_SCAN;
            pass_end = j_ff == last_idx;
         end
         default: begin
         end
      endcase

      if (p_valid_ff && p_op_ff == ALU_SCAN) begin
         best_in = alu_result;
      end

      j_in       = (issuing && !pass_end) ? j_ff + AW'(1) : '0;
      p_valid_in = issuing;
      p_addr_in  = j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         drop_ff    <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         drop_ff    <= drop_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      ovf_ff    <= ovf_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      p_op_ff   <= p_op_in;
      p_addr_ff <= p_addr_in;
      vi_ff     <= vi_in;
      diag_ff   <= diag_in;
      best_ff   <= best_in;
   end

   assign status.idle       = state_ff == ST_IDLE;
   assign status.resp_valid = state_ff == ST_RESP;
   assign best              = best_ff;
   assign overflow          = ovf_ff;
   assign val_waddr         = cnt_ff[AW-1:0];
   assign row_we            = p_valid_ff && (p_op_ff != ALU_SCAN);
   assign row_waddr         = p_addr_ff;
   assign alu_op            = p_op_ff;
   assign alu_a             = vi_ff;
   assign alu_diag          = diag_ff;

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ITEMS))
      else $error("store count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req.is_last) |=> (state_ff == ST_TAIL_RD && n_ff != '0))
      else $error("final request did not start the program");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (j_ff <= i_ff && CW'(i_ff) < nm1))
      else $error("sweep index out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT || state_ff == ST_SCAN) |-> (CW'(j_ff) < n_ff))
      else $error("row index beyond stored count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> !p_valid_ff)
      else $error("result shown while row update pending");

endmodule

`default_nettype wire

FILE: rtl/longest_nonincreasing_subsequence_core.sv
`default_nettype none

// longest non-increasing subsequence engine. requests carry one signed 16-bit
// value each and are taken one per cycle while loading; the request with
// is_last set closes the sequence (it is stored too if there is room). up to
// MAX_ITEMS values are kept, later ones are dropped and reported through the
// overflow bit of the response. after the final request the block runs a
// backward dynamic program over one working row held in a single-port-read
// memory, stepping one row entry per cycle within a pass through one shared
// compare/max unit; req_ready stays low from the acceptance of the final
// request until the response is taken. the row memory's one read address per
// cycle sets the pace of the program. length saturates at 63.

module longest_nonincreasing_subsequence_core import lnis_pkg::*; #(
   parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   // address width of the stores and width of counts / row entries
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = (CW > LENGTH_W) ? CW : LENGTH_W;

   seq_status_type            status;
   logic [CW-1:0]             best;
   logic                      overflow;
   logic                      val_we;
   logic [AW-1:0]             val_waddr;
   logic signed [VALUE_W-1:0] val_rdata;
   logic                      row_we;
   logic [AW-1:0]             row_waddr;
   logic [CW-1:0]             row_rdata;
   logic [AW-1:0]             rd_addr;
   alu_op_type                alu_op;
   logic signed [VALUE_W-1:0] alu_a;
   logic [CW-1:0]             alu_diag;
   logic [CW-1:0]             alu_result;
   logic [SW-1:0]             best_wide;

   // sequencer: loading, table walk, result hold
   lnis_seq #(
      .MAX_ITEMS (MAX_ITEMS),
      .AW        (AW),
      .CW        (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .best       (best),
      .overflow   (overflow),
      .val_we     (val_we),
      .val_waddr  (val_waddr),
      .val_rdata  (val_rdata),
      .row_we     (row_we),
      .row_waddr  (row_waddr),
      .row_rdata  (row_rdata),
      .rd_addr    (rd_addr),
      .alu_op     (alu_op),
      .alu_a      (alu_a),
      .alu_diag   (alu_diag),
      .alu_result (alu_result)
   );

   // stored sequence values
   lnis_ram #(
      .WIDTH  (VALUE_W),
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (AW)
   ) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (req.value),
      .raddr (rd_addr),
      .rdata (val_rdata)
   );

   // working row of the program, updated in place
   lnis_ram #(
      .WIDTH  (CW),
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (AW)
   ) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (alu_result),
      .raddr (rd_addr),
      .rdata (row_rdata)
   );

   // shared compare / max unit; compares the held value against the one read
   lnis_alu #(
      .LW (CW)
   ) u_alu (
      .op     (alu_op),
      .a_val  (alu_a),
      .b_val  (val_rdata),
      .below  (row_rdata),
      .diag   (alu_diag),
      .best   (best),
      .result (alu_result)
   );

   // response: saturate the length to the field width
   assign best_wide = SW'(best);

   always_comb begin
      if (best_wide > SW'(LENGTH_MAX)) begin
         rsp.length = LENGTH_MAX;
      end else begin
         rsp.length = best_wide[LENGTH_W-1:0];
      end
      rsp.overflow = overflow;
   end

   assign req_ready = status.idle;
   assign rsp_valid = status.resp_valid;

endmodule

`default_nettype wire
